// File: src/tst_pkg.sv
// Shared types, constants and address helpers for the taint shadow tracker.
// Depends on nothing; every other file imports it.
`default_nettype none

package tst_pkg;

  // Shadow window and register file size
  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned REG_COUNT = 16;

  // Byte lanes: one per byte of the widest access
  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_BITS = $clog2(LANES);
  localparam int unsigned ROW_BITS  = ADDR_BITS - LANE_BITS;
  localparam int unsigned ROWS      = 1 << ROW_BITS;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);

  // Fixed field widths of the request beats
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned BYTES_W = 4;
  localparam int unsigned REG_W   = 4;
  localparam int unsigned MEM_W   = 16;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [LANE_BITS-1:0] lane_t;
  typedef logic [BYTES_W-1:0]   bytes_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_MON_RESET  = 4'd0,
    REQ_REG_READ   = 4'd1,
    REQ_REG_WRITE  = 4'd2,
    REQ_HOST_LOAD  = 4'd3,
    REQ_HOST_STORE = 4'd4,
    REQ_GUEST_LOAD = 4'd5,
    REQ_GUEST_STORE = 4'd6,
    REQ_MARK       = 4'd7,
    REQ_NEXT_BLOCK = 4'd8,
    REQ_MARK_BLOCK = 4'd9,
    REQ_BRANCH     = 4'd10,
    REQ_CLEAR      = 4'd11
  } req_type_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Command to one byte lane
  typedef struct packed {
    logic rd;
    logic wr_guest;
    logic wr_host;
    logic wdata;
    row_t row;
  } lane_req_t;

  // Registered read data of one byte lane
  typedef struct packed {
    logic guest;
    logic host;
  } lane_rsp_t;

  // Row seen by lane k: lanes below the start lane belong to the next row
  function automatic row_t lane_row(addr_t a, lane_t k);
    lane_t lo;
    row_t  r;
    lo = a[LANE_BITS-1:0];
    r  = a[ADDR_BITS-1:LANE_BITS];
    return (k >= lo) ? r : row_t'(r + 1'b1);
  endfunction

  // Lane k is touched when its distance from the start lane is below the count
  function automatic logic lane_hit(addr_t a, bytes_t n, lane_t k);
    lane_t d;
    d = lane_t'(k - a[LANE_BITS-1:0]);
    return BYTES_W'(d) < n;
  endfunction

endpackage

`default_nettype wire

// File: src/tst_if.sv
// Request and result channel interfaces of the taint shadow tracker.
// Depends on tst_pkg for field widths.
`default_nettype none

interface tst_req_if;
  import tst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    req_type;
  logic [BYTES_W-1:0]   access_bytes;
  logic [REG_W-1:0]     reg_a;
  logic [REG_W-1:0]     reg_b;
  logic                 pair_load;
  logic [MEM_W-1:0]     mem_base;
  logic [MEM_W-1:0]     mem_offset;

  modport source (
    output valid, req_type, access_bytes, reg_a, reg_b, pair_load, mem_base, mem_offset,
    input  ready
  );
  modport sink (
    input  valid, req_type, access_bytes, reg_a, reg_b, pair_load, mem_base, mem_offset,
    output ready
  );
endinterface

interface tst_rsp_if;
  logic valid;
  logic ready;
  logic access_tainted;
  logic read_flag;
  logic block_symbolic;
  logic block_branching;

  modport source (
    output valid, access_tainted, read_flag, block_symbolic, block_branching,
    input  ready
  );
  modport sink (
    input  valid, access_tainted, read_flag, block_symbolic, block_branching,
    output ready
  );
endinterface

`default_nettype wire

// File: src/taint_shadow_tracker.sv
// Taint shadow tracker: register taint file, eight byte lanes of guest and
// host shadow memory, merge stage and control. Depends on tst_pkg, tst_if,
// tst_lane and tst_merge.
// Sequence: lanes are read at the accepting edge, the next cycle executes and loads
//   the result register, which then drives rsp_o.valid.
// A new beat is accepted only in idle, after the read-then-write of the lane banks.
// A clear beat adds a sweep over all 2^(ADDR_BITS-3) rows (8192 rows).
// Reset: async, active low; flags and register taint clear at once, then the same
//   clearing sweep runs before the first beat is accepted.
`default_nettype none

module taint_shadow_tracker (
  input  logic      clk_i,
  input  logic      rst_ni,
  tst_req_if.sink   req_i,
  tst_rsp_if.source rsp_o
);
  import tst_pkg::*;

  state_e state_q, state_d;
  row_t   sweep_q;

  // Latched request
  req_type_e type_q;
  bytes_t    n_q;
  logic [REG_W-1:0] ra_q, rb_q;
  logic      pair_q;
  addr_t     addr_q;

  // Architectural taint state
  logic [REG_COUNT-1:0] reg_taint_q, reg_taint_d;
  logic rf_q, rf_d, blk_q, blk_d, br_q, br_d;

  // Output register
  logic out_valid_q;
  logic out_seen_q, out_rf_q, out_blk_q, out_br_q;

  logic      in_ready, req_fire;
  bytes_t    n_in;
  addr_t     addr_in;
  lane_req_t lane_req [LANES];
  lane_rsp_t lane_rsp [LANES];
  logic [LANES-1:0] hit, lane_wr;
  logic      lane_seen, seen;
  logic      guest_wr, host_wr, wval;
  logic      ra_ok, rb_ok, reg_rd;

  // Input beat decode
  assign req_fire = req_i.valid && in_ready;
  assign n_in     = (req_i.access_bytes > bytes_t'(LANES)) ? bytes_t'(LANES)
                                                            : req_i.access_bytes;
  always_comb begin
    if (req_i.req_type == REQ_HOST_LOAD || req_i.req_type == REQ_HOST_STORE) begin
      addr_in = addr_t'(addr_t'(req_i.mem_base) + addr_t'(req_i.mem_offset));
    end else begin
      addr_in = addr_t'(req_i.mem_base);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q <= req_type_e'(req_i.req_type);
      n_q    <= n_in;
      ra_q   <= req_i.reg_a;
      rb_q   <= req_i.reg_b;
      pair_q <= req_i.pair_load;
      addr_q <= addr_in;
    end
  end

  // Register file access
  assign ra_ok  = 32'(ra_q) < REG_COUNT;
  assign rb_ok  = 32'(rb_q) < REG_COUNT;
  assign reg_rd = ra_ok ? reg_taint_q[REG_IDX_W'(ra_q)] : 1'b0;

  // Store source and target shadow
  always_comb begin
    guest_wr = 1'b0;
    host_wr  = 1'b0;
    wval     = 1'b0;
    unique case (type_q)
      REQ_HOST_STORE: begin
        host_wr = 1'b1;
        wval    = rf_q;
      end
      REQ_GUEST_STORE: begin
        guest_wr = 1'b1;
        wval     = (n_q == bytes_t'(LANES)) ? rf_q : reg_rd;
      end
      REQ_MARK: begin
        guest_wr = 1'b1;
        wval     = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_fire) state_d = ST_EXEC;
      ST_EXEC:  state_d = (type_q == REQ_CLEAR) ? ST_CLEAR : ST_IDLE;
      ST_CLEAR: if (sweep_q == '1) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // FSM outputs: handshake and lane commands
  always_comb begin
    in_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
    for (int k = 0; k < LANES; k++) begin
      hit[k]               = lane_hit(addr_q, n_q, lane_t'(k));
      lane_req[k].rd       = 1'b0;
      lane_req[k].wr_guest = 1'b0;
      lane_req[k].wr_host  = 1'b0;
      lane_req[k].wdata    = 1'b0;
      lane_req[k].row      = lane_row(addr_q, lane_t'(k));
      unique case (state_q)
        ST_IDLE: begin
          lane_req[k].rd  = req_fire;
          lane_req[k].row = lane_row(addr_in, lane_t'(k));
        end
        ST_EXEC: begin
          lane_req[k].wr_guest = guest_wr && hit[k];
          lane_req[k].wr_host  = host_wr && hit[k];
          lane_req[k].wdata    = wval;
        end
        ST_CLEAR: begin
          lane_req[k].wr_guest = 1'b1;
          lane_req[k].wr_host  = 1'b1;
          lane_req[k].row      = sweep_q;
        end
        default: ;
      endcase
      lane_wr[k] = lane_req[k].wr_guest | lane_req[k].wr_host;
    end
  end

  assign req_i.ready = in_ready;

  // Byte lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tst_lane u_lane (
      .clk_i (clk_i),
      .req_i (lane_req[g]),
      .rsp_o (lane_rsp[g])
    );
  end

  tst_merge u_merge (
    .rsp_i      (lane_rsp),
    .hit_i      (hit),
    .sel_host_i (type_q == REQ_HOST_LOAD),
    .seen_o     (lane_seen)
  );

  // Execute: update taint state
  always_comb begin
    rf_d        = rf_q;
    blk_d       = blk_q;
    br_d        = br_q;
    reg_taint_d = reg_taint_q;
    seen        = 1'b0;
    if (state_q == ST_EXEC) begin
      unique case (type_q)
        REQ_MON_RESET: rf_d = 1'b0;
        REQ_REG_READ: begin
          seen = reg_rd;
          if (reg_rd) begin
            rf_d  = 1'b1;
            blk_d = 1'b1;
          end
        end
        REQ_REG_WRITE: begin
          if (rf_q) blk_d = 1'b1;
          if (ra_ok) reg_taint_d[REG_IDX_W'(ra_q)] = rf_q;
        end
        REQ_HOST_LOAD, REQ_GUEST_LOAD: begin
          seen = lane_seen;
          if (lane_seen) blk_d = 1'b1;
          if (ra_ok) reg_taint_d[REG_IDX_W'(ra_q)] = lane_seen;
          if (type_q == REQ_GUEST_LOAD && pair_q && rb_ok) begin
            reg_taint_d[REG_IDX_W'(rb_q)] = lane_seen;
          end
        end
        REQ_HOST_STORE, REQ_GUEST_STORE, REQ_MARK: begin
          if (wval && (|hit)) blk_d = 1'b1;
        end
        REQ_NEXT_BLOCK: begin
          blk_d = 1'b0;
          br_d  = 1'b0;
        end
        REQ_MARK_BLOCK: blk_d = 1'b1;
        REQ_BRANCH:     br_d  = 1'b1;
        REQ_CLEAR: begin
          reg_taint_d = '0;
          blk_d       = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Control and taint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      reg_taint_q <= '0;
      rf_q        <= 1'b0;
      blk_q       <= 1'b0;
      br_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= (state_q == ST_CLEAR) ? row_t'(sweep_q + 1'b1) : '0;
      reg_taint_q <= reg_taint_d;
      rf_q        <= rf_d;
      blk_q       <= blk_d;
      br_q        <= br_d;
      if (state_q == ST_EXEC) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      out_seen_q <= seen;
      out_rf_q   <= rf_d;
      out_blk_q  <= blk_d;
      out_br_q   <= br_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.access_tainted  = out_seen_q;
  assign rsp_o.read_flag       = out_rf_q;
  assign rsp_o.block_symbolic  = out_blk_q;
  assign rsp_o.block_branching = out_br_q;

`ifndef SYNTHESIS
  // An accepted beat is executed in the next cycle
  a_fire_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == ST_EXEC)
    else $error("accepted beat not executed");

  // Execution never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !out_valid_q)
    else $error("result register overwritten");

  // Register taint stays empty while the shadow sweep runs
  a_sweep_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> reg_taint_q == '0)
    else $error("register taint set during clear sweep");

  // A zero-byte access writes no lane
  a_zero_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && n_q == '0) |-> lane_wr == '0)
    else $error("lane written on empty access");
`endif

endmodule

`default_nettype wire

// File: src/tst_lane.sv
// One byte lane: guest and host shadow bits for every row of the window.
// Depends on tst_pkg.
`default_nettype none

module tst_lane (
  input  logic               clk_i,
  input  tst_pkg::lane_req_t req_i,
  output tst_pkg::lane_rsp_t rsp_o
);
  import tst_pkg::*;

  logic      guest_mem [ROWS];
  logic      host_mem  [ROWS];
  lane_rsp_t rsp_q;

  // Single-port banks, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_guest) begin
      guest_mem[req_i.row] <= req_i.wdata;
    end
    if (req_i.wr_host) begin
      host_mem[req_i.row] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rsp_q.guest <= guest_mem[req_i.row];
      rsp_q.host  <= host_mem[req_i.row];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// File: src/tst_merge.sv
// Merge stage: ORs the taint of the touched lanes of the selected shadow.
// Depends on tst_pkg.
`default_nettype none

module tst_merge (
  input  tst_pkg::lane_rsp_t            rsp_i [tst_pkg::LANES],
  input  logic [tst_pkg::LANES-1:0]     hit_i,
  input  logic                          sel_host_i,
  output logic                          seen_o
);
  import tst_pkg::*;

  // Reduce over lanes
  always_comb begin
    seen_o = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      if (hit_i[k]) begin
        seen_o = seen_o | (sel_host_i ? rsp_i[k].host : rsp_i[k].guest);
      end
    end
  end

endmodule

`default_nettype wire
